// ===== sv/rotated_mono_frame_buffer_plotter_macros.svh =====
// assertion macros for the frame buffer plotter
// used by the top level, expects clk and rst in scope
`ifndef ROTATED_MONO_FRAME_BUFFER_PLOTTER_MACROS_SVH
`define ROTATED_MONO_FRAME_BUFFER_PLOTTER_MACROS_SVH
`ifndef SYNTH
`define RMFB_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rmfb invariant failed");
`define RMFB_ASSERT_IMPLY(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rmfb implication failed");
`define RMFB_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rmfb next-cycle check failed");
`else
`define RMFB_ASSERT_ALWAYS(label, cond)
`define RMFB_ASSERT_IMPLY(label, pre, post)
`define RMFB_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== sv/rmfb_pkg.sv =====
// shared types, codes and sizes for the frame buffer plotter
// no dependencies
`timescale 1ns / 1ps

package rmfb_pkg;

  localparam int MAX_WIDTH   = 800;
  localparam int MAX_HEIGHT  = 480;
  localparam int STORE_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / 8;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SUM_W       = ADDR_W + 3;
  localparam int Q_DEPTH     = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [9:0] W_CAP = 10'((MAX_WIDTH / 8) * 8);
  localparam logic [8:0] H_CAP = 9'(MAX_HEIGHT);
  localparam logic [7:0] PIX_MSB = 8'h80;

  localparam logic [1:0] CMD_PLOT = 2'd0;
  localparam logic [1:0] CMD_FILL = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_CLIPPED = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROT    = 2'd2;
  localparam logic [1:0] REG_INV    = 2'd3;

  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef enum logic [1:0] {
    K_REPLY,
    K_PLOT,
    K_FILL,
    K_READ
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PLOT,
    BK_READ,
    BK_FILL
  } bk_state_t;

  typedef struct packed {
    logic [9:0] width;
    logic [8:0] height;
    logic [1:0] rotation;
    logic       invert;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
    logic              set;
    logic [1:0]        status;
  } job_t;

endpackage

// ===== sv/rotated_mono_frame_buffer_plotter.sv =====
// rotated 1-bit-per-pixel frame buffer plotter, top level
// fill writes w*h/8 store bytes, one store byte per cycle, before its result; the
// back end starts no new plot or read until the store access of the last one is done
// reset: synchronous, clears queues and control, registers to 800/480/0/0
// store contents are undefined until written, no clearing pass
`timescale 1ns / 1ps
`include "rotated_mono_frame_buffer_plotter_macros.svh"

module rotated_mono_frame_buffer_plotter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [rmfb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      cmd,
  input  logic signed [11:0]              pos_x,
  input  logic signed [11:0]              pos_y,
  input  logic                            ink,
  input  logic [15:0]                     byte_index,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      status,
  output logic [7:0]                      read_byte
);

  import rmfb_pkg::*;

  cfg_t cfg;
  job_t fr_job;
  job_t q_job;
  logic fr_busy;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width    <= 10'd800;
      cfg.height   <= 9'd480;
      cfg.rotation <= 2'd0;
      cfg.invert   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  cfg.width    <= cfg_data[9:0];
        REG_HEIGHT: cfg.height   <= cfg_data[8:0];
        REG_ROT:    cfg.rotation <= cfg_data[1:0];
        REG_INV:    cfg.invert   <= cfg_data[0];
        default:    cfg.invert   <= cfg.invert;
      endcase
    end
  end

  rmfb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .ink       (ink),
    .byte_index(byte_index),
    .busy      (fr_busy),
    .q_push    (q_push),
    .q_full    (q_full),
    .job       (fr_job)
  );

  rmfb_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (fr_job),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_job),
    .empty(q_empty)
  );

  rmfb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job      (q_job),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .status   (status),
    .read_byte(read_byte)
  );

  `RMFB_ASSERT_NEXT(a_front_holds_item, push && !full, fr_busy)
  `RMFB_ASSERT_ALWAYS(a_queue_flags, !(q_empty && q_full))
  `RMFB_ASSERT_IMPLY(a_status_code, !empty, status != 2'd3)
  `RMFB_ASSERT_IMPLY(a_byte_zero_on_error, !empty && status != ST_DONE, read_byte == 8'd0)

endmodule

// ===== sv/rmfb_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module rmfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/rmfb_front.sv =====
// front end: accepts items, clips and rotates plots, builds byte jobs
// depends on rmfb_pkg
`timescale 1ns / 1ps

module rmfb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  rmfb_pkg::cfg_t       cfg,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           cmd,
  input  logic signed [11:0]   pos_x,
  input  logic signed [11:0]   pos_y,
  input  logic                 ink,
  input  logic [15:0]          byte_index,
  output logic                 busy,
  output logic                 q_push,
  input  logic                 q_full,
  output rmfb_pkg::job_t       job
);

  import rmfb_pkg::*;

  typedef struct packed {
    kind_t             kind;
    logic [8:0]        op_a;
    logic [9:0]        op_b;
    logic [ADDR_W-1:0] op_c;
    logic [2:0]        bitpos;
    logic              set;
    logic [1:0]        status;
  } stage_t;

  logic        stg_valid;
  stage_t      stg;
  stage_t      stg_next;
  logic        accept;
  logic [10:0] w_round;
  logic [9:0]  w_act;
  logic [8:0]  h_act;
  logic [9:0]  x_lim;
  logic [9:0]  y_lim;
  logic        clip;
  logic [9:0]  ux;
  logic [9:0]  uy;
  logic [9:0]  ax;
  logic [8:0]  ay;
  logic        pix_set;
  logic [SUM_W-1:0] prod;
  logic [SUM_W-1:0] sum;

  assign q_push = stg_valid && !q_full;
  assign full   = stg_valid && !q_push;
  assign accept = push && !full;
  assign busy   = stg_valid;

  always_comb begin
    w_round = ({1'b0, cfg.width} + 11'd7) & 11'h7F8;
    w_act   = (w_round > {1'b0, W_CAP}) ? W_CAP : w_round[9:0];
    h_act   = (cfg.height > H_CAP) ? H_CAP : cfg.height;
    x_lim   = cfg.rotation[0] ? {1'b0, h_act} : w_act;
    y_lim   = cfg.rotation[0] ? w_act : {1'b0, h_act};
    clip    = pos_x[11] || pos_y[11] || (pos_x[10:0] >= {1'b0, x_lim})
              || (pos_y[10:0] >= {1'b0, y_lim});
    ux      = pos_x[9:0];
    uy      = pos_y[9:0];
    case (cfg.rotation)
      ROT_90: begin
        ax = w_act - 10'd1 - uy;
        ay = ux[8:0];
      end
      ROT_180: begin
        ax = w_act - 10'd1 - ux;
        ay = h_act - 9'd1 - uy[8:0];
      end
      ROT_270: begin
        ax = uy;
        ay = h_act - 9'd1 - ux[8:0];
      end
      default: begin
        ax = ux;
        ay = uy[8:0];
      end
    endcase
    pix_set = cfg.invert ? ink : !ink;

    stg_next.kind   = K_REPLY;
    stg_next.op_a   = '0;
    stg_next.op_b   = w_act;
    stg_next.op_c   = '0;
    stg_next.bitpos = ax[2:0];
    stg_next.set    = pix_set;
    stg_next.status = ST_DONE;
    case (cmd)
      CMD_PLOT: begin
        if (clip) begin
          stg_next.status = ST_CLIPPED;
        end else begin
          stg_next.kind = K_PLOT;
          stg_next.op_a = ay;
          stg_next.op_c = ADDR_W'(ax);
        end
      end
      CMD_FILL: begin
        stg_next.kind = K_FILL;
        stg_next.op_a = h_act;
      end
      CMD_READ: begin
        if (byte_index >= 16'(STORE_DEPTH)) begin
          stg_next.status = ST_RANGE;
        end else begin
          stg_next.kind = K_READ;
          stg_next.op_c = ADDR_W'(byte_index);
        end
      end
      default: begin
        stg_next.status = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (q_push) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg <= stg_next;
    end
  end

  // byte address is (x + y * w) / 8, fill count is w * h / 8
  assign prod = SUM_W'(stg.op_a) * SUM_W'(stg.op_b);
  assign sum  = prod + SUM_W'(stg.op_c);

  always_comb begin
    job.kind   = stg.kind;
    job.addr   = (stg.kind == K_READ) ? stg.op_c : sum[SUM_W-1:3];
    job.mask   = PIX_MSB >> stg.bitpos;
    job.set    = stg.set;
    job.status = stg.status;
  end

endmodule

// ===== sv/rmfb_queue.sv =====
// short job queue between front and back end
// depends on rmfb_pkg
`timescale 1ns / 1ps

module rmfb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rmfb_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output rmfb_pkg::job_t dout,
  output logic           empty
);

  import rmfb_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);

  job_t             entries [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PTR_W + 1)'(Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

// ===== sv/rmfb_back.sv =====
// back end: byte read-modify-write, fill sweep, byte read, result register
// depends on rmfb_pkg and rmfb_ram
`timescale 1ns / 1ps

module rmfb_back (
  input  logic           clk,
  input  logic           rst,
  input  rmfb_pkg::job_t job,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [1:0]     status,
  output logic [7:0]     read_byte
);

  import rmfb_pkg::*;

  bk_state_t         state;
  bk_state_t         state_next;
  job_t              cur;
  logic [ADDR_W-1:0] cnt;
  logic              out_valid;
  logic              out_load;
  logic [1:0]        out_status_next;
  logic [7:0]        out_byte_next;
  logic              can_start;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [7:0]        ram_rdata;

  rmfb_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(job.addr),
    .rdata(ram_rdata)
  );

  assign can_start = !q_empty && (!out_valid || pop);

  always_comb begin
    state_next      = state;
    q_pop           = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = cur.addr;
    ram_wdata       = cur.set ? (ram_rdata | cur.mask) : (ram_rdata & ~cur.mask);
    ram_re          = 1'b0;
    out_load        = 1'b0;
    out_status_next = ST_DONE;
    out_byte_next   = 8'd0;
    case (state)
      BK_IDLE: begin
        if (can_start) begin
          q_pop = 1'b1;
          case (job.kind)
            K_PLOT: begin
              ram_re     = 1'b1;
              state_next = BK_PLOT;
            end
            K_READ: begin
              ram_re     = 1'b1;
              state_next = BK_READ;
            end
            K_FILL: begin
              if (job.addr == '0) begin
                out_load = 1'b1;
              end else begin
                state_next = BK_FILL;
              end
            end
            default: begin
              out_load        = 1'b1;
              out_status_next = job.status;
            end
          endcase
        end
      end
      BK_PLOT: begin
        ram_we     = 1'b1;
        out_load   = 1'b1;
        state_next = BK_IDLE;
      end
      BK_READ: begin
        out_load      = 1'b1;
        out_byte_next = ram_rdata;
        state_next    = BK_IDLE;
      end
      BK_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = cur.set ? 8'hFF : 8'h00;
        if (cnt == cur.addr - 1'b1) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= job;
      cnt <= '0;
    end else if (state == BK_FILL) begin
      cnt <= cnt + 1'b1;
    end
    if (out_load) begin
      status    <= out_status_next;
      read_byte <= out_byte_next;
    end
  end

  assign empty = !out_valid;

endmodule
